/* design/eecg_pkg.sv */
// shared constants and types for the echo envelope column to gray core
package eecg_pkg;
    localparam int MaxSamples = 4096;
    localparam int SampleBits = 12;
    localparam int MaxPixels  = 64;
    localparam int StoreDepth = MaxSamples / 2 + 1;
    localparam int AddrBits   = $clog2(StoreDepth);
    localparam int CountBits  = $clog2(MaxSamples + 1);
    localparam int HeightBits = 7;
    localparam int IdxBits    = 6;
    localparam int NumBits    = AddrBits + IdxBits + 1;
    localparam int ValBits    = SampleBits + IdxBits + 1;
    localparam int DenBits    = SampleBits + IdxBits;
    localparam int QuoBits    = 9;
    localparam int DivNumBits = ValBits + 10;

    typedef struct packed {
        logic                  start;
        logic [DivNumBits-1:0] num;
        logic [DenBits+1:0]    den;
        logic [4:0]            steps;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DivNumBits-1:0] quo;
        logic [DenBits+1:0]    rem;
    } div_rsp_t;

    function automatic logic [15:0] gray565(input logic [7:0] s);
        gray565 = {s[7:3], s[7:2], s[7:3]};
    endfunction
endpackage

/* design/eecg_div.sv */
// shared restoring divider, one quotient bit per cycle
module eecg_div
    import eecg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [DivNumBits-1:0] quo_reg, quo_next;
    logic [DenBits+1:0]    rem_reg, rem_next, den_reg;
    logic [4:0]            cnt_reg, cnt_next;
    logic                  busy_reg, busy_next, done_reg, done_next;
    logic [DenBits+2:0]    trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DivNumBits-1]};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DivNumBits-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = (DenBits+2)'(trial - {1'b0, den_reg});
                quo_next[0] = 1'b1;
            end
            else
                rem_next = trial[DenBits+1:0];
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (req.start)
            den_reg <= req.den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp = '{done: done_reg, quo: quo_reg, rem: rem_reg};

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start && req.steps != 5'd0 |=> busy_reg) else $error("start lost");
`endif
endmodule

/* design/echo_envelope_column_to_gray_core.sv */
// Collects envelope peaks of one echo column and emits output_height gray pixels.
// Samples are taken one per cycle; a column end then holds the input off
// while pixels are computed: per pixel one 19-step divide for the resampling
// index, two envelope reads, one multiply and a 29-step divide for the shade
// (skipped when the column maximum is zero; the first pixel also waits for the
// pending final write when the last transfer also ends a slope peak), each pixel
// held until taken downstream.
module echo_envelope_column_to_gray_core
    import eecg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [HeightBits-1:0] cfg_wdata,
    input  logic                  valid_in,
    output logic                  ready_in,
    input  logic [11:0]           sample,
    input  logic                  last,
    output logic                  valid_out,
    input  logic                  ready_out,
    output logic [15:0]           pixel_rgb565,
    output logic [5:0]            pixel_index,
    output logic                  last_pixel,
    output logic                  overflowed
);
    typedef enum logic [7:0] {
        S_COLLECT = 8'b00000001,
        S_IDIV    = 8'b00000010,
        S_RD0     = 8'b00000100,
        S_RD1     = 8'b00001000,
        S_MUL     = 8'b00010000,
        S_SDIV    = 8'b00100000,
        S_SWAIT   = 8'b01000000,
        S_OUT     = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [SampleBits-1:0] env_mem [StoreDepth];
    logic [SampleBits-1:0] rd_reg, e0_reg;
    logic [AddrBits-1:0]   rd_addr;
    logic                  wr_en;
    logic [AddrBits-1:0]   wr_addr;
    logic [SampleBits-1:0] wr_data;

    logic [HeightBits-1:0] height_reg;
    logic [AddrBits-1:0]   peak_reg, peak_next;
    logic [SampleBits-1:0] prev_reg, max_reg;
    logic                  slope_reg, ovf_reg;
    logic [CountBits-1:0]  count_reg;
    logic [IdxBits-1:0]    pix_reg;
    logic [IdxBits-1:0]    hm1_reg;
    logic [AddrBits-1:0]   idx_reg;
    logic [IdxBits-1:0]    p_reg;
    logic [ValBits-1:0]    v_reg;
    logic [15:0]           pixel_reg;
    logic                  outv_reg;
    div_req_t              dreq;
    div_rsp_t              drsp;

    logic                  take, accepted;
    logic [HeightBits-1:0] hsat;
    logic                  nonneg;
    logic                  slope_pk, fin_pend;
    logic [SampleBits-1:0] fin_data;
    logic [NumBits-1:0]    k;
    logic [DenBits+1:0]    den;
    logic [QuoBits-1:0]    shade;

    assign ready_in = state_reg == S_COLLECT;
    assign take     = valid_in && ready_in;
    assign accepted = take && count_reg < CountBits'(MaxSamples);
    assign nonneg   = sample >= prev_reg;
    assign hsat     = height_reg < 7'd2 ? 7'd2 :
                      (height_reg > HeightBits'(MaxPixels) ? HeightBits'(MaxPixels)
                                                           : height_reg);
    assign slope_pk = accepted && count_reg != '0 && slope_reg && !nonneg
                      && peak_reg < AddrBits'(StoreDepth);
    assign fin_data = accepted ? sample : prev_reg;

    // envelope write: peak on slope turn, final sample on column end
    always_comb
    begin
        wr_en     = 1'b0;
        wr_data   = prev_reg;
        wr_addr   = peak_reg;
        peak_next = peak_reg;
        fin_pend  = 1'b0;
        if (slope_pk)
        begin
            wr_en     = 1'b1;
            peak_next = peak_reg + 1'b1;
        end
        if (take && last && peak_next < AddrBits'(StoreDepth))
        begin
            // single write port: a final point behind a slope peak goes in next cycle
            if (slope_pk)
                fin_pend = 1'b1;
            else
            begin
                wr_en   = 1'b1;
                wr_addr = peak_next;
                wr_data = fin_data;
            end
            peak_next = peak_next + 1'b1;
        end
    end

    // collision case: slope peak and final sample in the same transfer
    logic                  pend_reg;
    logic [SampleBits-1:0] pend_data_reg;

    always_ff @(posedge clk)
    begin
        if (pend_reg)
            env_mem[peak_reg - 1'b1] <= pend_data_reg;
        else if (wr_en)
            env_mem[wr_addr] <= wr_data;
        rd_reg <= env_mem[rd_addr];
    end

    always_comb
    begin
        k   = NumBits'(pix_reg) * NumBits'(peak_reg - 1'b1);
        den = (DenBits+2)'(hm1_reg) * (DenBits+2)'(max_reg);
        dreq = '{start: 1'b0, num: '0, den: '0, steps: '0};
        rd_addr = idx_reg;
        state_next = state_reg;
        shade = drsp.quo[QuoBits-1:0];
        unique case (state_reg)
            S_COLLECT:
                if (take && last)
                    state_next = S_IDIV;
            S_IDIV:
            begin
                if (!pend_reg)
                begin
                    dreq = '{start: 1'b1, num: DivNumBits'(k) << (DivNumBits - NumBits),
                             den: (DenBits+2)'(hm1_reg), steps: 5'(NumBits)};
                    state_next = S_RD0;
                end
            end
            S_RD0:
                if (drsp.done)
                begin
                    rd_addr = pix_reg == hm1_reg ? peak_reg - 1'b1
                                                 : drsp.quo[AddrBits-1:0];
                    state_next = S_RD1;
                end
            S_RD1:
            begin
                rd_addr = idx_reg + 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
                state_next = S_SDIV;
            S_SDIV:
            begin
                if (max_reg != '0)
                begin
                    dreq = '{start: 1'b1,
                             num: (DivNumBits'(v_reg) * DivNumBits'(510) + DivNumBits'(den))
                                  << (DivNumBits - ValBits - 10),
                             den: den << 1, steps: 5'(ValBits + 10)};
                    state_next = S_SWAIT;
                end
                else
                    state_next = S_OUT;
            end
            S_SWAIT:
                if (drsp.done)
                    state_next = S_OUT;
            S_OUT:
                if (outv_reg && ready_out)
                    state_next = pix_reg == hm1_reg ? S_COLLECT : S_IDIV;
            default:
                state_next = S_COLLECT;
        endcase
    end

    eecg_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_RD0:
                if (drsp.done)
                begin
                    if (pix_reg == hm1_reg)
                    begin
                        idx_reg <= peak_reg - 1'b1;
                        p_reg   <= '0;
                    end
                    else
                    begin
                        idx_reg <= drsp.quo[AddrBits-1:0];
                        p_reg   <= drsp.rem[IdxBits-1:0];
                    end
                end
                else if (pix_reg == hm1_reg)
                    idx_reg <= peak_reg - 1'b1;
            S_RD1:
                e0_reg <= rd_reg;
            S_MUL:
                v_reg <= ValBits'(hm1_reg - p_reg) * ValBits'(e0_reg)
                         + (p_reg != '0 ? ValBits'(p_reg) * ValBits'(rd_reg) : '0);
            S_SWAIT:
                if (drsp.done)
                    pixel_reg <= gray565(shade > 9'd255 ? 8'd255 : shade[7:0]);
            S_SDIV:
                if (max_reg == '0)
                    pixel_reg <= '0;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_COLLECT;
            height_reg <= HeightBits'(MaxPixels);
            peak_reg   <= '0;
            prev_reg   <= '0;
            max_reg    <= '0;
            slope_reg  <= 1'b1;
            ovf_reg    <= 1'b0;
            count_reg  <= '0;
            pix_reg    <= '0;
            hm1_reg    <= '0;
            outv_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            pend_data_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= fin_pend;
            if (fin_pend)
                pend_data_reg <= fin_data;
            if (cfg_we)
                height_reg <= cfg_wdata;
            if (take)
            begin
                peak_reg <= peak_next;
                if (accepted)
                begin
                    slope_reg <= count_reg == '0 ? 1'b1 : nonneg;
                    if (sample > max_reg)
                        max_reg <= sample;
                    prev_reg  <= sample;
                    count_reg <= count_reg + 1'b1;
                end
                else
                    ovf_reg <= 1'b1;
                if (last)
                begin
                    hm1_reg <= IdxBits'(hsat - 7'd1);
                    pix_reg <= '0;
                end
            end
            if (state_reg == S_SWAIT && drsp.done)
                outv_reg <= 1'b1;
            if (state_reg == S_SDIV && max_reg == '0)
                outv_reg <= 1'b1;
            if (state_reg == S_OUT && outv_reg && ready_out)
            begin
                outv_reg <= 1'b0;
                pix_reg  <= pix_reg + 1'b1;
                if (pix_reg == hm1_reg)
                begin
                    peak_reg  <= '0;
                    prev_reg  <= '0;
                    max_reg   <= '0;
                    slope_reg <= 1'b1;
                    ovf_reg   <= 1'b0;
                    count_reg <= '0;
                end
            end
        end
    end

    assign valid_out    = outv_reg;
    assign pixel_rgb565 = pixel_reg;
    assign pixel_index  = pix_reg;
    assign last_pixel   = pix_reg == hm1_reg;
    assign overflowed   = ovf_reg;

`ifndef NO_ASSERTIONS
    a_out_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out |-> state_reg == S_OUT) else $error("pixel outside output state");
    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_COLLECT |-> !ready_in) else $error("input taken while busy");
    a_clear_after_col: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && ready_out && last_pixel |=> count_reg == '0)
        else $error("column state not cleared");
    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg <= AddrBits'(StoreDepth)) else $error("peak count overrun");
`endif
endmodule
